// ===== rtl/srar_pkg.sv =====
package srar_pkg;

    // ring geometry
    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;

    // field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int AMT_W      = 16;
    localparam int OUT_CNT_W  = 13;
    localparam int OUT_IDX_W  = 12;
    localparam int CLIP_W     = (CNT_W > AMT_W) ? CNT_W : AMT_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

    // opcodes on the input channel
    localparam logic [OP_W-1:0] OP_WRITE = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SENT  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_ACKED = OP_W'(2);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SENT,
        CMD_ACKED,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data_byte;
        logic               burst_last;
        logic [AMT_W-1:0]   amount;
    } cmd_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] done_count;
        logic [OUT_CNT_W-1:0] burst_accepted;
        logic [OUT_CNT_W-1:0] unsent_count;
        logic [OUT_CNT_W-1:0] inflight_count;
        logic [OUT_CNT_W-1:0] free_count;
        logic [OUT_CNT_W-1:0] contiguous_unsent;
        logic [OUT_IDX_W-1:0] send_index;
        logic [BYTE_W-1:0]    next_unsent_byte;
    } res_t;

    // ring position plus a count, wrapped once
    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] pos,
                                                      input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + SUM_W'(n);
        if (sum >= SUM_W'(RING_DEPTH))
        begin
            sum = sum - SUM_W'(RING_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    // requested count saturated at what is available
    function automatic logic [CNT_W-1:0] clip_count(input logic [AMT_W-1:0] want,
                                                    input logic [CNT_W-1:0] avail);
        logic [CLIP_W-1:0] want_x;
        logic [CLIP_W-1:0] avail_x;
        want_x  = CLIP_W'(want);
        avail_x = CLIP_W'(avail);
        return (want_x < avail_x) ? CNT_W'(want_x) : avail;
    endfunction

endpackage

// ===== rtl/srar_ram.sv =====
module srar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== rtl/srar_front.sv =====
module srar_front
    import srar_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   opcode,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              burst_last,
    input  logic [AMT_W-1:0]  amount,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic [Q_IDX_W-1:0] head_reg, head_next;
    logic [Q_IDX_W-1:0] tail;
    cmd_t               slot_reg [Q_DEPTH];
    cmd_t               decoded;
    logic               push;
    logic               pop;

    // classify the opcode
    always_comb
    begin
        decoded.data_byte  = data_byte;
        decoded.burst_last = burst_last;
        decoded.amount     = amount;
        case (opcode)
            OP_WRITE: decoded.kind = CMD_WRITE;
            OP_SENT:  decoded.kind = CMD_SENT;
            OP_ACKED: decoded.kind = CMD_ACKED;
            default:  decoded.kind = CMD_NOP;
        endcase
    end

    // queue handshakes
    assign in_ready  = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[head_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign tail      = head_reg + Q_IDX_W'(count_reg);

    // queue pointers
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
        if (pop)
        begin
            head_next = head_reg + Q_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    // queue slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= decoded;
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue over its depth");
`endif

endmodule

// ===== rtl/srar_back.sv =====
module srar_back
    import srar_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output res_t res
);

    // ring state
    logic [PTR_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [PTR_W-1:0]     send_ptr_reg, send_ptr_next;
    logic [CNT_W-1:0]     stored_reg, stored_next;
    logic [CNT_W-1:0]     unsent_reg, unsent_next;
    logic [OUT_CNT_W-1:0] burst_reg, burst_next;

    // result pipeline
    logic                 s1_valid_reg, s1_valid_next;
    res_t                 s1_res_reg;
    logic                 s1_has_unsent_reg;
    logic                 s1_fwd_reg;
    logic [BYTE_W-1:0]    s1_fwd_byte_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg;

    logic                 exec_fire;
    logic                 s1_move;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rd_data;
    logic [CNT_W-1:0]     inflight;
    logic [CNT_W-1:0]     done;
    logic [OUT_CNT_W-1:0] burst_inc;
    logic [OUT_CNT_W-1:0] burst_report;
    logic [CNT_W-1:0]     to_wrap;
    logic [CNT_W-1:0]     contig;
    logic                 has_unsent;
    logic                 fwd;
    res_t                 exec_res;
    res_t                 s1_done_res;

    // stage flow
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign cmd_ready = !s1_valid_reg || s1_move;
    assign exec_fire = cmd_valid && cmd_ready;

    // pointer and count update for one command
    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        send_ptr_next = send_ptr_reg;
        stored_next   = stored_reg;
        unsent_next   = unsent_reg;
        burst_inc     = burst_reg;
        burst_next    = burst_reg;
        ram_we        = 1'b0;
        done          = '0;
        inflight      = stored_reg - unsent_reg;
        case (cmd.kind)
            CMD_WRITE:
            begin
                if (stored_reg != DEPTH_CNT)
                begin
                    ram_we      = exec_fire;
                    wr_idx_next = ring_advance(wr_idx_reg, CNT_W'(1));
                    stored_next = stored_reg + CNT_W'(1);
                    unsent_next = unsent_reg + CNT_W'(1);
                    burst_inc   = burst_reg + OUT_CNT_W'(1);
                    done        = CNT_W'(1);
                end
                burst_next = cmd.burst_last ? '0 : burst_inc;
            end
            CMD_SENT:
            begin
                done          = clip_count(cmd.amount, unsent_reg);
                send_ptr_next = ring_advance(send_ptr_reg, done);
                unsent_next   = unsent_reg - done;
            end
            CMD_ACKED:
            begin
                done        = clip_count(cmd.amount, inflight);
                stored_next = stored_reg - done;
            end
            default:
            begin
                done = '0;
            end
        endcase
        burst_report = burst_inc;
    end

    // status taken after the update
    always_comb
    begin
        has_unsent = (unsent_next != '0);
        to_wrap    = DEPTH_CNT - CNT_W'(send_ptr_next);
        if (!has_unsent)
        begin
            contig = '0;
        end
        else
        begin
            contig = (unsent_next < to_wrap) ? unsent_next : to_wrap;
        end
        exec_res.done_count        = OUT_CNT_W'(done);
        exec_res.burst_accepted    = burst_report;
        exec_res.unsent_count      = OUT_CNT_W'(unsent_next);
        exec_res.inflight_count    = OUT_CNT_W'(stored_next - unsent_next);
        exec_res.free_count        = OUT_CNT_W'(DEPTH_CNT - stored_next);
        exec_res.contiguous_unsent = OUT_CNT_W'(contig);
        exec_res.send_index        = OUT_IDX_W'(send_ptr_next);
        exec_res.next_unsent_byte  = '0;
    end

    // byte written this cycle at the new send index bypasses the ram
    assign fwd = ram_we && (wr_idx_reg == send_ptr_next);

    srar_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data (cmd.data_byte),
        .rd_en   (exec_fire),
        .rd_addr (send_ptr_next),
        .rd_data (ram_rd_data)
    );

    // merge the byte at the send index
    always_comb
    begin
        s1_done_res = s1_res_reg;
        if (!s1_has_unsent_reg)
        begin
            s1_done_res.next_unsent_byte = '0;
        end
        else if (s1_fwd_reg)
        begin
            s1_done_res.next_unsent_byte = s1_fwd_byte_reg;
        end
        else
        begin
            s1_done_res.next_unsent_byte = ram_rd_data;
        end
    end

    // valid flags of both stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            send_ptr_reg  <= '0;
            stored_reg    <= '0;
            unsent_reg    <= '0;
            burst_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                wr_idx_reg   <= wr_idx_next;
                send_ptr_reg <= send_ptr_next;
                stored_reg   <= stored_next;
                unsent_reg   <= unsent_next;
                burst_reg    <= burst_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            s1_res_reg        <= exec_res;
            s1_has_unsent_reg <= has_unsent;
            s1_fwd_reg        <= fwd;
            s1_fwd_byte_reg   <= cmd.data_byte;
        end
        if (s1_move)
        begin
            out_res_reg <= s1_done_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_res_reg;

`ifndef SYNTHESIS
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= DEPTH_CNT)
        else $error("stored count above ring depth");

    a_unsent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unsent_reg <= stored_reg)
        else $error("unsent count above stored count");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (unsent_reg == '0) |-> (send_ptr_reg == wr_idx_reg))
        else $error("send and write index differ with nothing unsent");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_res_reg)))
        else $error("stalled result stage lost its item");
`endif

endmodule

// ===== rtl/send_ack_retransmit_ring.sv =====
// Stream send buffer on a byte ring with write, send and acknowledge positions.
// Items carry an opcode: write stores one byte unless the ring is full, sent
// moves the send index by amount saturated at the unsent bytes, acked frees
// bytes saturated at the sent but unacknowledged bytes; any other opcode only
// reports status. Each item gives one result with the counts after its update,
// the unsent run up to the ring's end and the byte at the send index. The block
// takes one item per cycle while the output is not held back; the pointer and
// count update in the back end sets that figure. Each result passes the result
// stage and the output register before it is offered. A two-entry command queue
// sits between the input decode and the ring update, and the byte at the send
// index comes from a registered read of the ring memory, with a bypass for a byte
// written by the same item. Ring contents need no clearing after reset.
module send_ack_retransmit_ring
    import srar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      opcode,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 burst_last,
    input  logic [AMT_W-1:0]     amount,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_CNT_W-1:0] done_count,
    output logic [OUT_CNT_W-1:0] burst_accepted,
    output logic [OUT_CNT_W-1:0] unsent_count,
    output logic [OUT_CNT_W-1:0] inflight_count,
    output logic [OUT_CNT_W-1:0] free_count,
    output logic [OUT_CNT_W-1:0] contiguous_unsent,
    output logic [OUT_IDX_W-1:0] send_index,
    output logic [BYTE_W-1:0]    next_unsent_byte
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    res_t res;

    // decode and queue
    srar_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .burst_last (burst_last),
        .amount     (amount),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    // ring update and result
    srar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign done_count        = res.done_count;
    assign burst_accepted    = res.burst_accepted;
    assign unsent_count      = res.unsent_count;
    assign inflight_count    = res.inflight_count;
    assign free_count        = res.free_count;
    assign contiguous_unsent = res.contiguous_unsent;
    assign send_index        = res.send_index;
    assign next_unsent_byte  = res.next_unsent_byte;

endmodule
